### rtl/core/absolute_humidity_bilinear_lookup_unit_assert.svh
// assertion macros for the absolute humidity lookup unit
// expects clk and arst_n in the scope of the module that uses them
`ifndef ABSOLUTE_HUMIDITY_BILINEAR_LOOKUP_UNIT_ASSERT_SVH
`define ABSOLUTE_HUMIDITY_BILINEAR_LOOKUP_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AHBL_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ahbl assertion failed");

// next-cycle implication, checked out of reset
`define AHBL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ahbl assertion failed");

`endif

### rtl/core/ahbl_pkg.sv
// shared types, constants, rom image and crc helper for the humidity lookup
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ahbl_pkg;

	localparam int GRID_N  = 20;
	localparam int BANK_N  = 10;
	localparam int BANK_D  = BANK_N * BANK_N;
	localparam int CELL_Q8 = 1280;
	localparam int LOW_Q8  = 1280;
	localparam int HIGH_Q8 = 25600;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hff;

	// datapath widths
	localparam int E_W  = 16;  // table entry
	localparam int W_W  = 11;  // cell weight, 0..1279
	localparam int A_W  = 27;  // one-axis blend
	localparam int N_W  = 37;  // two-axis blend
	localparam int DIV_SHIFT = 10;          // 640000 = 2^10 * 625
	localparam int X_W  = N_W - DIV_SHIFT;  // dividend for the divide by 625
	localparam int M_W  = 31;
	localparam int P_W  = X_W + M_W;
	localparam int RECIP_SHIFT = 40;
	localparam int Q_W  = P_W - RECIP_SHIFT;
	localparam logic [M_W-1:0] RECIP_625 = 31'd1759218605;  // ceil(2^40 / 625)

	typedef logic [E_W-1:0] bank_t [BANK_D];

	typedef struct packed {
		logic           in_range;
		logic           r0_odd;
		logic           c0_odd;
		logic [W_W-1:0] wt;
		logic [W_W-1:0] wh;
	} cell_t;

	typedef struct packed {
		logic           vld;
		logic           ok;
		logic [15:0]    q8;
		logic [7:0]     crc_hi;
	} res_t;

	// absolute humidity in 0.01 g/m3, row = temperature step, column = humidity step
	localparam logic [E_W-1:0] AH_ROM [GRID_N*GRID_N] = '{
		16'd34, 16'd68, 16'd102, 16'd136, 16'd170, 16'd204, 16'd238, 16'd272, 16'd306, 16'd340,
		16'd373, 16'd407, 16'd441, 16'd475, 16'd509, 16'd543, 16'd577, 16'd611, 16'd645, 16'd679,
		16'd47, 16'd94, 16'd141, 16'd188, 16'd235, 16'd282, 16'd329, 16'd376, 16'd423, 16'd470,
		16'd516, 16'd563, 16'd610, 16'd657, 16'd704, 16'd751, 16'd798, 16'd845, 16'd892, 16'd939,
		16'd64, 16'd128, 16'd192, 16'd256, 16'd321, 16'd385, 16'd449, 16'd513, 16'd577, 16'd641,
		16'd705, 16'd769, 16'd833, 16'd897, 16'd962, 16'd1026, 16'd1090, 16'd1154, 16'd1218,
		16'd1282,
		16'd86, 16'd173, 16'd259, 16'd345, 16'd432, 16'd518, 16'd604, 16'd691, 16'd777, 16'd864,
		16'd950, 16'd1036, 16'd1123, 16'd1209, 16'd1295, 16'd1382, 16'd1468, 16'd1554, 16'd1641,
		16'd1727,
		16'd115, 16'd230, 16'd345, 16'd460, 16'd575, 16'd690, 16'd805, 16'd920, 16'd1035,
		16'd1151, 16'd1266, 16'd1381, 16'd1496, 16'd1611, 16'd1726, 16'd1841, 16'd1956, 16'd2071,
		16'd2186, 16'd2301,
		16'd152, 16'd303, 16'd455, 16'd606, 16'd758, 16'd909, 16'd1061, 16'd1212, 16'd1364,
		16'd1516, 16'd1667, 16'd1819, 16'd1970, 16'd2122, 16'd2273, 16'd2425, 16'd2576, 16'd2728,
		16'd2879, 16'd3031,
		16'd198, 16'd395, 16'd593, 16'd790, 16'd988, 16'd1185, 16'd1383, 16'd1580, 16'd1778,
		16'd1976, 16'd2173, 16'd2371, 16'd2568, 16'd2766, 16'd2963, 16'd3161, 16'd3358, 16'd3556,
		16'd3753, 16'd3951,
		16'd255, 16'd510, 16'd765, 16'd1020, 16'd1275, 16'd1530, 16'd1785, 16'd2040, 16'd2295,
		16'd2550, 16'd2805, 16'd3060, 16'd3315, 16'd3570, 16'd3825, 16'd4080, 16'd4335, 16'd4590,
		16'd4845, 16'd5100,
		16'd326, 16'd652, 16'd978, 16'd1304, 16'd1630, 16'd1956, 16'd2282, 16'd2608, 16'd2934,
		16'd3261, 16'd3587, 16'd3913, 16'd4239, 16'd4565, 16'd4891, 16'd5217, 16'd5543, 16'd5869,
		16'd6195, 16'd6521,
		16'd413, 16'd827, 16'd1240, 16'd1653, 16'd2066, 16'd2480, 16'd2893, 16'd3306, 16'd3719,
		16'd4133, 16'd4546, 16'd4959, 16'd5372, 16'd5786, 16'd6199, 16'd6612, 16'd7025, 16'd7439,
		16'd7852, 16'd8265,
		16'd519, 16'd1039, 16'd1558, 16'd2078, 16'd2597, 16'd3117, 16'd3636, 16'd4156, 16'd4675,
		16'd5195, 16'd5714, 16'd6233, 16'd6753, 16'd7272, 16'd7792, 16'd8311, 16'd8831, 16'd9350,
		16'd9870, 16'd10389,
		16'd648, 16'd1295, 16'd1943, 16'd2591, 16'd3239, 16'd3886, 16'd4534, 16'd5182, 16'd5829,
		16'd6477, 16'd7125, 16'd7772, 16'd8420, 16'd9068, 16'd9716, 16'd10363, 16'd11011,
		16'd11659, 16'd12306, 16'd12954,
		16'd802, 16'd1603, 16'd2405, 16'd3206, 16'd4008, 16'd4809, 16'd5611, 16'd6412, 16'd7214,
		16'd8015, 16'd8817, 16'd9618, 16'd10420, 16'd11221, 16'd12023, 16'd12824, 16'd13626,
		16'd14427, 16'd15229, 16'd16030,
		16'd985, 16'd1969, 16'd2954, 16'd3939, 16'd4924, 16'd5908, 16'd6893, 16'd7878, 16'd8862,
		16'd9847, 16'd10832, 16'd11816, 16'd12801, 16'd13786, 16'd14771, 16'd15755, 16'd16740,
		16'd17725, 16'd18709, 16'd19694,
		16'd1202, 16'd2403, 16'd3605, 16'd4806, 16'd6008, 16'd7209, 16'd8411, 16'd9612, 16'd10814,
		16'd12016, 16'd13217, 16'd14419, 16'd15620, 16'd16822, 16'd18023, 16'd19225, 16'd20426,
		16'd21628, 16'd22829, 16'd24031,
		16'd1457, 16'd2913, 16'd4370, 16'd5827, 16'd7283, 16'd8740, 16'd10197, 16'd11653,
		16'd13110, 16'd14567, 16'd16023, 16'd17480, 16'd18936, 16'd20393, 16'd21850, 16'd23306,
		16'd24763, 16'd26220, 16'd27676, 16'd29133,
		16'd1755, 16'd3510, 16'd5265, 16'd7020, 16'd8775, 16'd10529, 16'd12284, 16'd14039,
		16'd15794, 16'd17549, 16'd19304, 16'd21059, 16'd22814, 16'd24569, 16'd26324, 16'd28078,
		16'd29833, 16'd31588, 16'd33343, 16'd35098,
		16'd2102, 16'd4204, 16'd6305, 16'd8407, 16'd10509, 16'd12611, 16'd14713, 16'd16814,
		16'd18916, 16'd21018, 16'd23120, 16'd25222, 16'd27323, 16'd29425, 16'd31527, 16'd33629,
		16'd35731, 16'd37832, 16'd39934, 16'd42036,
		16'd2503, 16'd5006, 16'd7509, 16'd10012, 16'd12515, 16'd15018, 16'd17521, 16'd20024,
		16'd22527, 16'd25030, 16'd27533, 16'd30036, 16'd32539, 16'd35042, 16'd37545, 16'd40048,
		16'd42551, 16'd45054, 16'd47557, 16'd50060,
		16'd2965, 16'd5930, 16'd8894, 16'd11859, 16'd14824, 16'd17789, 16'd20754, 16'd23718,
		16'd26683, 16'd29648, 16'd32613, 16'd35578, 16'd38542, 16'd41507, 16'd44472, 16'd47437,
		16'd50402, 16'd53366, 16'd56331, 16'd59296
	};

	// one parity bank: rows and columns of the given parity, packed 10 x 10
	function automatic bank_t bank_image(input int row_odd, input int col_odd);
		bank_t img;
		int r;
		int c;
		for (int i = 0; i < BANK_D; i++) begin
			r = 2 * (i / BANK_N) + row_odd;
			c = 2 * (i % BANK_N) + col_odd;
			img[i] = AH_ROM[r * GRID_N + c];
		end
		return img;
	endfunction

	// crc-8, msb first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/core/ahbl_rom_bank.sv
// one parity bank of the humidity table, synchronous read with registered data out
// depends on ahbl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ahbl_rom_bank #(
	parameter int ROW_ODD = 0,
	parameter int COL_ODD = 0
) (
	input  wire logic                     clk,
	input  wire logic [6:0]               addr,
	output logic [ahbl_pkg::E_W-1:0]      rd_data
);

	localparam ahbl_pkg::bank_t MEM = ahbl_pkg::bank_image(ROW_ODD, COL_ODD);

	logic [ahbl_pkg::E_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		rd_data_q <= MEM[addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/core/ahbl_cell.sv
// range check, cell index, in-cell weights and bank addresses for one reading
// depends on ahbl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ahbl_cell (
	input  wire logic signed [15:0]  temperature_q8,
	input  wire logic [14:0]         rel_humidity_q8,
	output ahbl_pkg::cell_t          loc,
	output logic [3:0][6:0]          bank_addr
);

	localparam logic [4:0] LAST_IDX = 5'(ahbl_pkg::GRID_N - 1);

	// grid index: offset / 1280 as (offset >> 8) / 5 by reciprocal 205 / 1024
	function automatic logic [4:0] axis_raw(input logic [14:0] off);
		logic [14:0] prod;
		prod = 15'(off[14:8]) * 15'd205;
		return prod[14:10];
	endfunction

	function automatic logic [4:0] axis_idx(input logic [14:0] off);
		logic [4:0] q;
		q = axis_raw(off);
		return (q > LAST_IDX) ? LAST_IDX : q;
	endfunction

	function automatic logic [ahbl_pkg::W_W-1:0] axis_w(input logic [14:0] off);
		logic [4:0] q;
		logic [6:0] rem;
		q = axis_raw(off);
		rem = off[14:8] - 7'(7'(q) * 7'd5);
		return {rem[2:0], off[7:0]};
	endfunction

	logic [15:0] t_off;
	logic [15:0] h_off;
	logic [4:0]  r0, r1, c0, c1;
	logic        in_range;

	assign in_range = (temperature_q8 >= ahbl_pkg::LOW_Q8) &&
		(temperature_q8 <= ahbl_pkg::HIGH_Q8) &&
		(rel_humidity_q8 >= ahbl_pkg::LOW_Q8) &&
		(rel_humidity_q8 <= ahbl_pkg::HIGH_Q8);

	assign t_off = temperature_q8 - 16'(ahbl_pkg::LOW_Q8);
	assign h_off = {1'b0, rel_humidity_q8} - 16'(ahbl_pkg::LOW_Q8);

	assign r0 = axis_idx(t_off[14:0]);
	assign c0 = axis_idx(h_off[14:0]);
	// upper neighbor clamps at the last row or column, its weight is zero there
	assign r1 = (r0 == LAST_IDX) ? LAST_IDX : r0 + 5'd1;
	assign c1 = (c0 == LAST_IDX) ? LAST_IDX : c0 + 5'd1;

	always_comb begin
		loc.in_range = in_range;
		loc.r0_odd   = r0[0];
		loc.c0_odd   = c0[0];
		loc.wt       = axis_w(t_off[14:0]);
		loc.wh       = axis_w(h_off[14:0]);
	end

	// bank index {row parity, column parity}; each corner lands in its own bank
	always_comb begin
		logic [4:0] row;
		logic [4:0] col;
		for (int b = 0; b < 4; b++) begin
			row = (r0[0] == b[1]) ? r0 : r1;
			col = (c0[0] == b[0]) ? c0 : c1;
			bank_addr[b] = ({3'b000, row[4:1]} << 3) + ({3'b000, row[4:1]} << 1) +
				{3'b000, col[4:1]};
		end
	end

endmodule

`default_nettype wire

### rtl/core/ahbl_interp.sv
// bilinear blend of four corners, scale to 8.8 and first crc byte
// depends on ahbl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ahbl_interp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                vld_s1,
	input  wire logic                                in_range_s1,
	input  wire logic [3:0][ahbl_pkg::E_W-1:0]       corner_s1,
	input  wire logic [ahbl_pkg::W_W-1:0]            wt_s1,
	input  wire logic [ahbl_pkg::W_W-1:0]            wh_s1,
	output ahbl_pkg::res_t                           res_s5
);

	localparam int A_W = ahbl_pkg::A_W;
	localparam int N_W = ahbl_pkg::N_W;
	localparam int P_W = ahbl_pkg::P_W;
	localparam int Q_W = ahbl_pkg::Q_W;
	localparam logic [ahbl_pkg::W_W-1:0] CELL = ahbl_pkg::W_W'(ahbl_pkg::CELL_Q8);

	logic                         vld_s2, vld_s3, vld_s4, vld_s5;
	logic                         in_range_s2, in_range_s3, in_range_s4;
	logic [ahbl_pkg::W_W-1:0]     wt_s2;
	logic [A_W-1:0]               a0_s2, a1_s2;
	logic [N_W-1:0]               n_s3;
	logic [P_W-1:0]               prod_s4;
	logic [Q_W-1:0]               q_s4;
	logic                         ok_s5;
	logic [15:0]                  q8_s5;
	logic [7:0]                   crc_hi_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// humidity axis blend, corners 0/1 on the lower row, 2/3 on the upper
	always_ff @(posedge clk) begin
		in_range_s2 <= in_range_s1;
		wt_s2       <= wt_s1;
		a0_s2 <= A_W'(corner_s1[0]) * A_W'(CELL - wh_s1) + A_W'(corner_s1[1]) * A_W'(wh_s1);
		a1_s2 <= A_W'(corner_s1[2]) * A_W'(CELL - wh_s1) + A_W'(corner_s1[3]) * A_W'(wh_s1);
	end

	// temperature axis blend
	always_ff @(posedge clk) begin
		in_range_s3 <= in_range_s2;
		n_s3 <= N_W'(a0_s2) * N_W'(CELL - wt_s2) + N_W'(a1_s2) * N_W'(wt_s2);
	end

	// divide by 640000: drop 2^10, then multiply by the reciprocal of 625
	always_ff @(posedge clk) begin
		in_range_s4 <= in_range_s3;
		prod_s4 <= P_W'(n_s3[N_W-1:ahbl_pkg::DIV_SHIFT]) * P_W'(ahbl_pkg::RECIP_625);
	end

	assign q_s4 = prod_s4[P_W-1:ahbl_pkg::RECIP_SHIFT];

	always_ff @(posedge clk) begin
		ok_s5     <= in_range_s4 && (q_s4 != '0) && (q_s4[Q_W-1:16] == '0);
		q8_s5     <= q_s4[15:0];
		crc_hi_s5 <= ahbl_pkg::crc8_byte(ahbl_pkg::CRC_INIT, q_s4[15:8]);
	end

	always_comb begin
		res_s5.vld    = vld_s5;
		res_s5.ok     = ok_s5;
		res_s5.q8     = q8_s5;
		res_s5.crc_hi = crc_hi_s5;
	end

endmodule

`default_nettype wire

### rtl/core/absolute_humidity_bilinear_lookup_unit.sv
// top level of the absolute humidity lookup: cell front end, rom banks, blend pipe
// depends on ahbl_pkg, ahbl_cell, ahbl_rom_bank, ahbl_interp and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "absolute_humidity_bilinear_lookup_unit_assert.svh"

// usage
// - input channel: a reading (temperature_q8, rel_humidity_q8) is taken as one beat
//   at a rising edge where start is high and busy is low
// - busy is high from reset until the first clock edge after reset lets go, then
//   stays low: the pipe takes one beat every cycle with no gaps
// - output channel: done is high for exactly one cycle per accepted beat, with
//   abs_hum_integer, abs_hum_fraction, check_byte and result_valid alongside
// - the receiver cannot stall; results leave in the order readings came in
// - stages: the accepting edge does the rom read, then come the humidity blend,
//   temperature blend, reciprocal multiply, scale check and output register, which
//   raises done
// - throughput: one beat per cycle, set by the four parity banks of the table, each
//   with one read port, so all four cell corners come back in the same cycle
// - readings outside 5 to 100 on either axis, and results of 256.0 or more or zero,
//   come out with result_valid low and all three bytes zero
// - check_byte is the crc-8 (poly 0x31, init 0xff) over the integer byte then the
//   fraction byte
// - reset clears the beat-valid pipe; data registers are left as they are

module absolute_humidity_bilinear_lookup_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] temperature_q8,
	input  wire logic [14:0]        rel_humidity_q8,
	output logic                    done,
	output logic [7:0]              abs_hum_integer,
	output logic [7:0]              abs_hum_fraction,
	output logic [7:0]              check_byte,
	output logic                    result_valid
);

	logic                                 busy_q;
	logic                                 in_accept;
	ahbl_pkg::cell_t                      loc;
	logic [3:0][6:0]                      bank_addr;
	logic [3:0][ahbl_pkg::E_W-1:0]        bank_data_s1;
	logic [3:0][ahbl_pkg::E_W-1:0]        corner_s1;
	logic                                 vld_s1;
	ahbl_pkg::cell_t                      loc_s1;
	ahbl_pkg::res_t                       res_s5;
	logic                                 done_q;
	logic                                 result_valid_q;
	logic [7:0]                           int_q;
	logic [7:0]                           frac_q;
	logic [7:0]                           crc_q;

	// not ready until the first edge out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign in_accept = start && !busy_q;

	// front end: range check and cell location straight off the ports
	ahbl_cell u_cell (
		.temperature_q8  (temperature_q8),
		.rel_humidity_q8 (rel_humidity_q8),
		.loc             (loc),
		.bank_addr       (bank_addr)
	);

	// four parity banks, bank index is {row odd, column odd}
	for (genvar b = 0; b < 4; b++) begin : g_bank
		ahbl_rom_bank #(
			.ROW_ODD (b / 2),
			.COL_ODD (b % 2)
		) u_bank (
			.clk     (clk),
			.addr    (bank_addr[b]),
			.rd_data (bank_data_s1[b])
		);
	end

	// stage 1 tags travel beside the rom read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		loc_s1 <= loc;
	end

	// route banks to corners: the lower row and column take the parity of r0 and c0
	always_comb begin
		corner_s1[0] = bank_data_s1[{loc_s1.r0_odd, loc_s1.c0_odd}];
		corner_s1[1] = bank_data_s1[{loc_s1.r0_odd, !loc_s1.c0_odd}];
		corner_s1[2] = bank_data_s1[{!loc_s1.r0_odd, loc_s1.c0_odd}];
		corner_s1[3] = bank_data_s1[{!loc_s1.r0_odd, !loc_s1.c0_odd}];
	end

	ahbl_interp u_interp (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld_s1      (vld_s1),
		.in_range_s1 (loc_s1.in_range),
		.corner_s1   (corner_s1),
		.wt_s1       (loc_s1.wt),
		.wh_s1       (loc_s1.wh),
		.res_s5      (res_s5)
	);

	// output register: finish the crc, zero everything on a rejected reading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			done_q         <= res_s5.vld;
			result_valid_q <= res_s5.vld && res_s5.ok;
		end
	end

	always_ff @(posedge clk) begin
		if (res_s5.ok) begin
			int_q  <= res_s5.q8[15:8];
			frac_q <= res_s5.q8[7:0];
			crc_q  <= ahbl_pkg::crc8_byte(res_s5.crc_hi, res_s5.q8[7:0]);
		end else begin
			int_q  <= 8'h00;
			frac_q <= 8'h00;
			crc_q  <= 8'h00;
		end
	end

	assign done             = done_q;
	assign result_valid     = result_valid_q;
	assign abs_hum_integer  = int_q;
	assign abs_hum_fraction = frac_q;
	assign check_byte       = crc_q;

	// one result for every accepted beat, and no others
	`AHBL_ASSERT_IMPLIES(a_beat_latency, 1'b1, done == $past(in_accept, 6))
	// a valid flag only ever rides on a strobe
	`AHBL_ASSERT_IMPLIES(a_valid_on_done, result_valid, done)
	// a rejected reading carries zero bytes
	`AHBL_ASSERT_IMPLIES(a_reject_zero, done && !result_valid,
		abs_hum_integer == 8'h00 && abs_hum_fraction == 8'h00 && check_byte == 8'h00)
	// once ready, the pipe never drops ready again
	`AHBL_ASSERT_NEXT(a_busy_stays_low, !busy, !busy)

endmodule

`default_nettype wire

### dv/tb_top.sv
// self-checking bench for absolute_humidity_bilinear_lookup_unit: directed and random readings
// drives beats from a queue, predicts each result with its own bilinear table lookup and crc-8
// depends on the rtl top level only
`timescale 1ns / 1ps

module tb_top;

	// grid of the lookup, all in q8 units
	localparam int GRID       = 20;
	localparam int STEP_Q8    = 1280;   // 5 degrees or 5 percent
	localparam int LOW_Q8     = 1280;   // 5.0
	localparam int HIGH_Q8    = 25600;  // 100.0
	localparam longint unsigned SCALE_DIV = 64'd163840000;  // 1280 * 1280 * 100 / 256 * 256
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_SEED = 8'hff;

	// limits on the readings the bench draws
	localparam int TEMP_MIN = -10240;
	localparam int TEMP_MAX = 32767;
	localparam int HUM_MAX  = 25600;

	localparam int RANDOM_BEATS = 450;
	localparam int QUIET_TAIL   = 80;   // last beats go out back to back
	localparam int DRAIN_CYCLES = 12;   // pipe is 6 deep, leave some margin
	localparam int PRINT_LIMIT  = 40;

	// absolute humidity in 0.01 g/m3, row = temperature step, column = humidity step
	localparam int unsigned AH_CENTI [GRID*GRID] = '{
		34,68,102,136,170,204,238,272,306,340,373,407,441,475,509,543,577,611,645,679,
		47,94,141,188,235,282,329,376,423,470,516,563,610,657,704,751,798,845,892,939,
		64,128,192,256,321,385,449,513,577,641,705,769,833,897,962,1026,1090,1154,1218,1282,
		86,173,259,345,432,518,604,691,777,864,950,1036,1123,1209,1295,1382,1468,1554,1641,
		1727,
		115,230,345,460,575,690,805,920,1035,1151,1266,1381,1496,1611,1726,1841,1956,2071,
		2186,2301,
		152,303,455,606,758,909,1061,1212,1364,1516,1667,1819,1970,2122,2273,2425,2576,2728,
		2879,3031,
		198,395,593,790,988,1185,1383,1580,1778,1976,2173,2371,2568,2766,2963,3161,3358,3556,
		3753,3951,
		255,510,765,1020,1275,1530,1785,2040,2295,2550,2805,3060,3315,3570,3825,4080,4335,4590,
		4845,5100,
		326,652,978,1304,1630,1956,2282,2608,2934,3261,3587,3913,4239,4565,4891,5217,5543,5869,
		6195,6521,
		413,827,1240,1653,2066,2480,2893,3306,3719,4133,4546,4959,5372,5786,6199,6612,7025,
		7439,7852,8265,
		519,1039,1558,2078,2597,3117,3636,4156,4675,5195,5714,6233,6753,7272,7792,8311,8831,
		9350,9870,10389,
		648,1295,1943,2591,3239,3886,4534,5182,5829,6477,7125,7772,8420,9068,9716,10363,11011,
		11659,12306,12954,
		802,1603,2405,3206,4008,4809,5611,6412,7214,8015,8817,9618,10420,11221,12023,12824,
		13626,14427,15229,16030,
		985,1969,2954,3939,4924,5908,6893,7878,8862,9847,10832,11816,12801,13786,14771,15755,
		16740,17725,18709,19694,
		1202,2403,3605,4806,6008,7209,8411,9612,10814,12016,13217,14419,15620,16822,18023,
		19225,20426,21628,22829,24031,
		1457,2913,4370,5827,7283,8740,10197,11653,13110,14567,16023,17480,18936,20393,21850,
		23306,24763,26220,27676,29133,
		1755,3510,5265,7020,8775,10529,12284,14039,15794,17549,19304,21059,22814,24569,26324,
		28078,29833,31588,33343,35098,
		2102,4204,6305,8407,10509,12611,14713,16814,18916,21018,23120,25222,27323,29425,31527,
		33629,35731,37832,39934,42036,
		2503,5006,7509,10012,12515,15018,17521,20024,22527,25030,27533,30036,32539,35042,37545,
		40048,42551,45054,47557,50060,
		2965,5930,8894,11859,14824,17789,20754,23718,26683,29648,32613,35578,38542,41507,44472,
		47437,50402,53366,56331,59296
	};

	// one reading as driven on the input ports
	typedef struct {
		logic signed [15:0] temp;
		logic [14:0]        hum;
	} reading_t;

	// what the output ports should show for one reading
	typedef struct {
		logic signed [15:0] temp;
		logic [14:0]        hum;
		logic [7:0]         int_byte;
		logic [7:0]         frac_byte;
		logic [7:0]         crc;
		logic               ok;
	} humidity_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [15:0] temperature_q8 = '0;
	logic [14:0] rel_humidity_q8 = '0;
	logic busy;
	logic done;
	logic [7:0] abs_hum_integer;
	logic [7:0] abs_hum_fraction;
	logic [7:0] check_byte;
	logic result_valid;

	reading_t         reading_queue [$];
	humidity_result_t humidity_expected [$];

	reading_t next_reading;
	humidity_result_t seen;
	bit beat_taken = 1'b0;   // set by the monitor at each rising edge
	int beats_total = 0;
	int beats_sent = 0;
	int beats_taken = 0;
	int quiet_after = 0;
	int idle_left = 0;
	int mismatch_count = 0;
	int valid_count = 0;
	int invalid_count = 0;

	absolute_humidity_bilinear_lookup_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.temperature_q8   (temperature_q8),
		.rel_humidity_q8  (rel_humidity_q8),
		.done             (done),
		.abs_hum_integer  (abs_hum_integer),
		.abs_hum_fraction (abs_hum_fraction),
		.check_byte       (check_byte),
		.result_valid     (result_valid)
	);

	always #5 clk = ~clk;

	// crc-8, msb first, over one byte
	function automatic logic [7:0] crc8_31(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// bilinear blend of the four cell corners, truncated to 8.8, plus crc
	function automatic humidity_result_t predict_abs_humidity(input logic signed [15:0] t,
			input logic [14:0] h);
		humidity_result_t res;
		int tv;
		int hv;
		int r0;
		int r1;
		int c0;
		int c1;
		int wt;
		int wh;
		longint unsigned blend;
		longint unsigned q8;
		tv = t;   // sign extends
		hv = h;   // zero extends
		res.temp = t;
		res.hum = h;
		res.int_byte = '0;
		res.frac_byte = '0;
		res.crc = '0;
		res.ok = 1'b0;
		if (tv < LOW_Q8 || tv > HIGH_Q8 || hv < LOW_Q8 || hv > HIGH_Q8) begin
			return res;
		end
		r0 = (tv - LOW_Q8) / STEP_Q8;
		wt = (tv - LOW_Q8) % STEP_Q8;
		c0 = (hv - LOW_Q8) / STEP_Q8;
		wh = (hv - LOW_Q8) % STEP_Q8;
		if (r0 > GRID - 1) r0 = GRID - 1;
		if (c0 > GRID - 1) c0 = GRID - 1;
		// at 100 the upper neighbour clamps onto the last row or column, with zero weight
		r1 = (r0 + 1 > GRID - 1) ? GRID - 1 : r0 + 1;
		c1 = (c0 + 1 > GRID - 1) ? GRID - 1 : c0 + 1;
		blend = longint'(AH_CENTI[r0*GRID + c0]) * (STEP_Q8 - wh) * (STEP_Q8 - wt)
		      + longint'(AH_CENTI[r0*GRID + c1]) * wh * (STEP_Q8 - wt)
		      + longint'(AH_CENTI[r1*GRID + c0]) * (STEP_Q8 - wh) * wt
		      + longint'(AH_CENTI[r1*GRID + c1]) * wh * wt;
		q8 = (blend * 256) / SCALE_DIV;
		// zero or 256.0 and up does not fit 8.8
		if (q8 == 0 || q8 > 64'hffff) begin
			return res;
		end
		res.int_byte = q8[15:8];
		res.frac_byte = q8[7:0];
		res.crc = crc8_31(crc8_31(CRC_SEED, q8[15:8]), q8[7:0]);
		res.ok = 1'b1;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("%0t mismatch: %s", $realtime, what);
		end
	endtask

	task automatic queue_reading(input int t, input int h);
		reading_t rd;
		rd.temp = t[15:0];
		rd.hum = h[14:0];
		reading_queue.push_back(rd);
	endtask

	// driver: new beat at the falling edge once the previous one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || beat_taken) begin
			if (idle_left > 0) begin
				start <= 1'b0;
				idle_left--;
			end else if (reading_queue.size() == 0) begin
				start <= 1'b0;
			end else if (beats_sent < quiet_after && $urandom_range(0, 5) == 0) begin
				// idle gap before the next beat, its length drawn at random into idle_left
				start <= 1'b0;
				idle_left = $urandom_range(0, 2);
			end else begin
				next_reading = reading_queue.pop_front();
				start <= 1'b1;
				temperature_q8 <= next_reading.temp;
				rel_humidity_q8 <= next_reading.hum;
				beats_sent++;
			end
		end
	end

	// monitor: takes accepted beats into the predictor and checks each result strobe
	always @(posedge clk) begin
		beat_taken = arst_n && start && !busy;
		if (arst_n && done === 1'b1) begin
			if (humidity_expected.size() == 0) begin
				report_mismatch("result strobe with no reading outstanding");
			end else begin
				seen = humidity_expected.pop_front();
				if (abs_hum_integer !== seen.int_byte)
					report_mismatch($sformatf("t=%0d h=%0d integer %0d, want %0d",
						seen.temp, seen.hum, abs_hum_integer, seen.int_byte));
				if (abs_hum_fraction !== seen.frac_byte)
					report_mismatch($sformatf("t=%0d h=%0d fraction %0d, want %0d",
						seen.temp, seen.hum, abs_hum_fraction, seen.frac_byte));
				if (check_byte !== seen.crc)
					report_mismatch($sformatf("t=%0d h=%0d crc %02h, want %02h",
						seen.temp, seen.hum, check_byte, seen.crc));
				if (result_valid !== seen.ok)
					report_mismatch($sformatf("t=%0d h=%0d valid %b, want %b",
						seen.temp, seen.hum, result_valid, seen.ok));
				if (seen.ok) valid_count++;
				else invalid_count++;
			end
		end
		if (beat_taken) begin
			humidity_expected.push_back(predict_abs_humidity(temperature_q8, rel_humidity_q8));
			beats_taken++;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int kind;
		int t;
		int h;

		// grid corners, range edges just in and just out
		queue_reading(LOW_Q8, LOW_Q8);
		queue_reading(HIGH_Q8, HIGH_Q8);          // top corner, too large for 8.8
		queue_reading(LOW_Q8 - 1, LOW_Q8);
		queue_reading(LOW_Q8, LOW_Q8 - 1);
		queue_reading(HIGH_Q8 + 1, 5000);
		queue_reading(5000, HIGH_Q8 + 1);
		queue_reading(LOW_Q8 + 1, LOW_Q8 + 1);
		queue_reading(HIGH_Q8 - 1, HIGH_Q8 - 1);
		queue_reading(HIGH_Q8, LOW_Q8);
		queue_reading(LOW_Q8, HIGH_Q8);
		// field extremes
		queue_reading(TEMP_MIN, 0);
		queue_reading(TEMP_MAX, HUM_MAX);
		queue_reading(0, 0);
		queue_reading(-1, 12800);
		queue_reading(16383, 16383);
		// exact grid points, including the clamped last row and column
		queue_reading(2560, 2560);
		queue_reading(12800, 12800);
		queue_reading(HIGH_Q8, 12800);
		queue_reading(12800, HIGH_Q8);
		// hot row either side of the 256.0 limit
		queue_reading(HIGH_Q8, 10240);
		queue_reading(HIGH_Q8, 11520);
		queue_reading(HIGH_Q8, 10880);
		// just below a grid line on both axes
		queue_reading(3839, 3839);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				// in range on both axes, any cell
				t = $urandom_range(LOW_Q8, HIGH_Q8);
				h = $urandom_range(LOW_Q8, HIGH_Q8);
			end else if (kind < 16) begin
				// exact grid points
				t = STEP_Q8 * $urandom_range(1, GRID);
				h = STEP_Q8 * $urandom_range(1, GRID);
			end else if (kind < 18) begin
				// one lsb around the range edges
				t = ($urandom_range(0, 1) ? HIGH_Q8 : LOW_Q8) + $urandom_range(0, 2) - 1;
				h = ($urandom_range(0, 1) ? HIGH_Q8 : LOW_Q8) + $urandom_range(0, 2) - 1;
			end else begin
				// anything within the bench limits of the reading
				t = $urandom_range(0, TEMP_MAX - TEMP_MIN) + TEMP_MIN;
				h = $urandom_range(0, HUM_MAX);
			end
			queue_reading(t, h);
		end
		beats_total = reading_queue.size();
		quiet_after = beats_total - QUIET_TAIL;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (beats_taken < beats_total) @(negedge clk);
		for (int k = 0; k < 4 * DRAIN_CYCLES && humidity_expected.size() != 0; k++)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (humidity_expected.size() != 0)
			report_mismatch($sformatf("%0d results never came out", humidity_expected.size()));

		$display("%0d readings sent (%0d directed); %0d results with valid high, %0d low",
			beats_total, beats_total - RANDOM_BEATS, valid_count, invalid_count);
		$display("%0d mismatches found", mismatch_count);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog, set far beyond the slowest expected run
	initial begin
		#500000;
		$display("timeout: %0d of %0d readings taken", beats_taken, beats_total);
		$display("== FAIL ==");
		$finish;
	end

endmodule
